// ----- rtl/core/fpa_pkg.sv -----
// Package: operation codes and pipeline word types for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int OUT_BITS = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] result;
    logic                cmp;
  } alu_out_t;

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [OUT_BITS-1:0] result;
    logic                cmp;
  } pipe_t;

endpackage
`default_nettype wire

// ----- rtl/core/fixed_point_alu_top.sv -----
// Top level of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
// A new word is taken on every clock (busy stays low) and each result appears
// after the same delay for every operation alike; the default format is Q24.8.
// That delay is set by the divider, which resolves one quotient bit per
// pipeline stage over the widened dividend; all other operations ride a
// matching delay line so results leave in order. out_valid marks each result
// for exactly one cycle and the receiver cannot hold it off, so capture it on
// that cycle. Operands use their low WORD_BITS bits as two's complement;
// results wrap and are sign-extended to 32 bits. Divide by zero gives 0 with
// out_divide_by_zero set.
module fixed_point_alu_top #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_BITS     = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_operation,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  output logic signed [31:0]      out_result,
  output logic                    out_compare_true,
  output logic                    out_divide_by_zero
);

  localparam int NB      = WORD_BITS + FRACTION_BITS;
  localparam int LATENCY = NB + 4;

  // Never stall the input: every stage advances each cycle.
  assign busy = 1'b0;

  // Stage 1: capture the word.
  logic                        s1_valid_r;
  fpa_pkg::op_t                s1_op_r;
  logic signed [WORD_BITS-1:0] s1_a_r;
  logic signed [WORD_BITS-1:0] s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
    end
    s1_op_r <= fpa_pkg::op_t'(in_operation);
    s1_a_r  <= in_operand_a[WORD_BITS-1:0];
    s1_b_r  <= in_operand_b[WORD_BITS-1:0];
  end

  fpa_pkg::alu_out_t           alu_out;
  logic [fpa_pkg::OUT_BITS-1:0] mul_out;
  logic [fpa_pkg::OUT_BITS-1:0] div_out;
  logic                         div_dz;

  fpa_alu #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk      (clk),
    .op       (s1_op_r),
    .a        (s1_a_r),
    .b        (s1_b_r),
    .alu_out_r(alu_out)
  );

  fpa_mul #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk       (clk),
    .a         (s1_a_r),
    .b         (s1_b_r),
    .prod_out_r(mul_out)
  );

  fpa_div #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .a     (s1_a_r),
    .b     (s1_b_r),
    .quot_r(div_out),
    .dz_r  (div_dz)
  );

  // Stages 2 and 3: carry valid and opcode alongside the ALU and multiplier.
  logic              s2_valid_r;
  fpa_pkg::op_t      s2_op_r;
  fpa_pkg::pipe_t    s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_r.valid  <= 1'b0;
    end else begin
      s2_valid_r  <= s1_valid_r;
      s3_r.valid  <= s2_valid_r;
    end
    s2_op_r     <= s1_op_r;
    s3_r.op     <= s2_op_r;
    s3_r.result <= alu_out.result;
    s3_r.cmp    <= alu_out.cmp;
  end

  // Merge the multiplier result, then hold the word in a delay line that
  // matches the divider depth.
  fpa_pkg::pipe_t line_nxt;
  fpa_pkg::pipe_t line_r [NB];

  always_comb begin
    line_nxt = s3_r;
    if (s3_r.op == fpa_pkg::OP_MUL) begin
      line_nxt.result = mul_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        line_r[i].valid <= 1'b0;
      end
    end else begin
      line_r[0].valid <= line_nxt.valid;
      for (int i = 1; i < NB; i++) begin
        line_r[i].valid <= line_r[i-1].valid;
      end
    end
    line_r[0].op     <= line_nxt.op;
    line_r[0].result <= line_nxt.result;
    line_r[0].cmp    <= line_nxt.cmp;
    for (int i = 1; i < NB; i++) begin
      line_r[i].op     <= line_r[i-1].op;
      line_r[i].result <= line_r[i-1].result;
      line_r[i].cmp    <= line_r[i-1].cmp;
    end
  end

  // Output stage: pick the divider result for divides, drive the strobe.
  logic                         is_div;
  logic [fpa_pkg::OUT_BITS-1:0] out_result_nxt;
  logic                         out_dz_nxt;

  always_comb begin
    is_div         = (line_r[NB-1].op == fpa_pkg::OP_DIV);
    out_result_nxt = is_div ? div_out : line_r[NB-1].result;
    out_dz_nxt     = is_div & div_dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= line_r[NB-1].valid;
    end
    out_result         <= out_result_nxt;
    out_compare_true   <= line_r[NB-1].cmp;
    out_divide_by_zero <= out_dz_nxt;
  end

  // Every accepted word comes out with out_valid set after the LATENCY delay.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY) out_valid)
    else $error("accepted word did not emerge after fixed latency");

  // A true compare never carries a nonzero result.
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_true) |-> (out_result == '0))
    else $error("compare result not zero");

  // Divide by zero gives a zero result and never a compare flag.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result == '0 && !out_compare_true))
    else $error("divide by zero result not clean");

endmodule
`default_nettype wire

// ----- rtl/core/fpa_alu.sv -----
// Registered unit for add, sub, compare, min/max, inc/dec and shifts.
`timescale 1ns / 1ps
`default_nettype none
module fpa_alu #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                        clk,
  input  wire fpa_pkg::op_t                op,
  input  wire logic signed [WORD_BITS-1:0] a,
  input  wire logic signed [WORD_BITS-1:0] b,
  output fpa_pkg::alu_out_t                alu_out_r
);

  logic signed [WORD_BITS-1:0] res;
  logic                        cmp;
  fpa_pkg::alu_out_t           alu_out_nxt;

  always_comb begin
    res = '0;
    cmp = 1'b0;
    unique case (op)
      fpa_pkg::OP_ADD:      res = a + b;
      fpa_pkg::OP_SUB:      res = a - b;
      fpa_pkg::OP_GT:       cmp = (a > b);
      fpa_pkg::OP_LT:       cmp = (a < b);
      fpa_pkg::OP_GE:       cmp = (a >= b);
      fpa_pkg::OP_LE:       cmp = (a <= b);
      fpa_pkg::OP_EQ:       cmp = (a == b);
      fpa_pkg::OP_NE:       cmp = (a != b);
      fpa_pkg::OP_MIN:      res = (a < b) ? a : b;
      fpa_pkg::OP_MAX:      res = (a > b) ? a : b;
      fpa_pkg::OP_INC:      res = a + WORD_BITS'(1);
      fpa_pkg::OP_DEC:      res = a - WORD_BITS'(1);
      fpa_pkg::OP_TO_INT:   res = a >>> FRACTION_BITS;
      fpa_pkg::OP_FROM_INT: res = a <<< FRACTION_BITS;
      default:              res = '0;
    endcase
    alu_out_nxt.result = fpa_pkg::OUT_BITS'(res);
    alu_out_nxt.cmp    = cmp;
  end

  always_ff @(posedge clk) begin
    alu_out_r <= alu_out_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/fpa_mul.sv -----
// Two-stage fixed-point multiplier: full product, then scale and wrap.
`timescale 1ns / 1ps
`default_nettype none
module fpa_mul #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic signed [WORD_BITS-1:0]        a,
  input  wire logic signed [WORD_BITS-1:0]        b,
  output logic         [fpa_pkg::OUT_BITS-1:0]    prod_out_r
);

  logic signed [2*WORD_BITS-1:0] prod_r;
  logic signed [2*WORD_BITS-1:0] prod_sh;
  logic signed [WORD_BITS-1:0]   prod_w;

  always_comb begin
    prod_sh = prod_r >>> FRACTION_BITS;
    prod_w  = prod_sh[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r     <= (2*WORD_BITS)'(a) * (2*WORD_BITS)'(b);
    prod_out_r <= fpa_pkg::OUT_BITS'(prod_w);
  end

endmodule
`default_nettype wire

// ----- rtl/core/fpa_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic signed [WORD_BITS-1:0]     a,
  input  wire logic signed [WORD_BITS-1:0]     b,
  output logic         [fpa_pkg::OUT_BITS-1:0] quot_r,
  output logic                                 dz_r
);

  localparam int NB = WORD_BITS + FRACTION_BITS;

  logic [WORD_BITS-1:0] rem_r [NB+1];
  logic [NB-1:0]        dq_r  [NB+1];
  logic [WORD_BITS-1:0] d_r   [NB+1];
  logic                 neg_r [NB+1];
  logic                 zero_r[NB+1];

  logic signed [NB-1:0] num;
  logic signed [NB-1:0] num_sh;

  always_comb begin
    num    = NB'(a);
    num_sh = num <<< FRACTION_BITS;
  end

  // Stage 0: take magnitudes and the quotient sign.
  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    dq_r[0]   <= num_sh[NB-1] ? (NB)'(-num_sh) : num_sh;
    d_r[0]    <= b[WORD_BITS-1] ? WORD_BITS'(-b) : b;
    neg_r[0]  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
    zero_r[0] <= (b == '0);
  end

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [WORD_BITS:0] trial;
    logic               ge;
    always_comb begin
      trial = {rem_r[s], dq_r[s][NB-1]};
      ge    = (trial >= {1'b0, d_r[s]});
    end
    always_ff @(posedge clk) begin
      rem_r[s+1]  <= ge ? WORD_BITS'(trial - {1'b0, d_r[s]}) : trial[WORD_BITS-1:0];
      dq_r[s+1]   <= {dq_r[s][NB-2:0], ge};
      d_r[s+1]    <= d_r[s];
      neg_r[s+1]  <= neg_r[s];
      zero_r[s+1] <= zero_r[s];
    end
  end

  logic signed [WORD_BITS-1:0] q_w;

  always_comb begin
    q_w = neg_r[NB] ? WORD_BITS'(-dq_r[NB][WORD_BITS-1:0]) : dq_r[NB][WORD_BITS-1:0];
    if (zero_r[NB]) begin
      q_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= fpa_pkg::OUT_BITS'(q_w);
    dz_r   <= zero_r[NB];
  end

endmodule
`default_nettype wire
